### rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; imported by every module of the block
package spq_pkg;

  localparam int DEPTH  = 8;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int DATA_W = VAL_W + PRI_W;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_ENQUEUED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_DEQUEUED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

endpackage

### rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus slot datapath
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: value, priority; tuser: cmd
//   m_*      out  m_tvalid/m_tready    tdata: value, priority; tuser: status
//
// compare and shift happen across all slots at once
// one result per item, held in an output register until taken
// a new item is taken in the same cycle that the held result leaves
// rst is synchronous and empties the queue; slot contents are not cleared
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // item_value[31:0], item_priority[47:32]
  input  logic              s_tuser,  // cmd[0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,  // out_value[31:0], out_priority[47:32]
  output logic [1:0]        m_tuser   // status[1:0]
);

  ctrl_cmd_t               cmd;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic signed [PRI_W-1:0] res_priority;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  spq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_cmd       (cmd_t'(s_tuser)),
    .in_value     (s_tdata[VAL_W-1:0]),
    .in_priority  (s_tdata[DATA_W-1:VAL_W]),
    .res_status   (res_status),
    .res_value    (res_value),
    .res_priority (res_priority)
  );

  assign m_tdata = {res_priority, res_value};
  assign m_tuser = res_status;

endmodule

### rtl/spq_ctrl.sv
// handshake controller: accepts items and holds the result register valid
// depends on spq_pkg
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   in_fire;

  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (m_tready && !in_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a new item may enter while the held result leaves in the same cycle
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_HOLD: begin
        s_tready = m_tready;
        m_tvalid = 1'b1;
      end
      default: s_tready = 1'b0;
    endcase
    cmd.exec = s_tvalid && s_tready;
  end

endmodule

### rtl/spq_datapath.sv
// slot row with per-slot compare and shift, occupancy count, result register
// depends on spq_pkg
module spq_datapath
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  cmd_t                    in_cmd,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [PRI_W-1:0] in_priority,
  output status_t                 res_status,
  output logic signed [VAL_W-1:0] res_value,
  output logic signed [PRI_W-1:0] res_priority
);

  logic signed [VAL_W-1:0] slot_value [DEPTH];
  logic signed [PRI_W-1:0] slot_priority [DEPTH];
  logic signed [VAL_W-1:0] slot_value_next [DEPTH];
  logic signed [PRI_W-1:0] slot_priority_next [DEPTH];
  logic [OCC_W-1:0]        occupancy;
  logic [DEPTH-1:0]        stay;
  logic                    full, empty, do_enq, do_deq;

  assign full   = (occupancy == OCC_W'(DEPTH));
  assign empty  = (occupancy == '0);
  assign do_enq = cmd.exec && (in_cmd == CMD_ENQ) && !full;
  assign do_deq = cmd.exec && (in_cmd == CMD_DEQ) && !empty;

  // live slots at or above the new priority keep their place
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign stay[i] = (occupancy > OCC_W'(i)) && (slot_priority[i] >= in_priority);

    always_comb begin
      slot_value_next[i]    = slot_value[i];
      slot_priority_next[i] = slot_priority[i];
      if (do_enq && !stay[i]) begin
        if (i == 0) begin
          slot_value_next[i]    = in_value;
          slot_priority_next[i] = in_priority;
        end else begin
          if (stay[(i == 0) ? 0 : i - 1]) begin
            slot_value_next[i]    = in_value;
            slot_priority_next[i] = in_priority;
          end else begin
            slot_value_next[i]    = slot_value[(i == 0) ? 0 : i - 1];
            slot_priority_next[i] = slot_priority[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (do_deq && (i < DEPTH - 1)) begin
        slot_value_next[i]    = slot_value[(i < DEPTH - 1) ? i + 1 : i];
        slot_priority_next[i] = slot_priority[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_value[i]    <= slot_value_next[i];
      slot_priority[i] <= slot_priority_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (do_enq) begin
      occupancy <= occupancy + OCC_W'(1);
    end else if (do_deq) begin
      occupancy <= occupancy - OCC_W'(1);
    end
  end

  // result register, loaded once per accepted item
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_value    <= in_value;
      res_priority <= in_priority;
      if (in_cmd == CMD_ENQ) begin
        res_status <= full ? STAT_FULL : STAT_ENQUEUED;
      end else if (empty) begin
        res_status <= STAT_EMPTY;
      end else begin
        res_status   <= STAT_DEQUEUED;
        res_value    <= slot_value[0];
        res_priority <= slot_priority[0];
      end
    end
  end

endmodule

### sim/tb_sorted_priority_queue.sv
// testbench for sorted_priority_queue: directed and random enqueue/dequeue traffic
// predicts each result with a behavioral sorted queue and checks the output stream
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value;
    logic [PRI_W-1:0]  prio;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;  // item_value[31:0], item_priority[47:32]
  logic              s_tuser = CMD_ENQ;  // cmd[0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;  // out_value[31:0], out_priority[47:32]
  logic [1:0]        m_tuser;  // status[1:0]

  // behavioral copy of the slots, head at index 0
  logic signed [VAL_W-1:0] pq_value[DEPTH];
  logic signed [PRI_W-1:0] pq_prio[DEPTH];
  int                      pq_count = 0;

  queue_result_t pending_results[$];
  int            error_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // works out the result of one accepted item and updates the slot copy
  task automatic predict_item(cmd_t cmd, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
    queue_result_t res;
    int pos;
    res.status = STAT_ENQUEUED;
    res.value  = val;
    res.prio   = pri;
    if (cmd == CMD_ENQ) begin
      if (pq_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pos = pq_count;
        // new item goes behind every entry of equal or higher priority
        while (pos > 0 && pq_prio[pos-1] < $signed(pri)) begin
          pq_value[pos] = pq_value[pos-1];
          pq_prio[pos]  = pq_prio[pos-1];
          pos--;
        end
        pq_value[pos] = val;
        pq_prio[pos]  = pri;
        pq_count++;
      end
    end else begin
      if (pq_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.status = STAT_DEQUEUED;
        res.value  = pq_value[0];
        res.prio   = pq_prio[0];
        for (int i = 1; i < pq_count; i++) begin
          pq_value[i-1] = pq_value[i];
          pq_prio[i-1]  = pq_prio[i];
        end
        pq_count--;
      end
    end
    pending_results.push_back(res);
  endtask

  // valid stays high after acceptance so back-to-back items need no toggle
  task automatic send_item(cmd_t cmd, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pri, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(cmd, val, pri);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    queue_result_t exp_res;
    queue_result_t act_res;
    if (!rst && m_tvalid && m_tready) begin
      act_res.status = status_t'(m_tuser);
      act_res.value  = m_tdata[VAL_W-1:0];
      act_res.prio   = m_tdata[DATA_W-1:VAL_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h priority %h", $time,
                 act_res.status, act_res.value, act_res.prio);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (act_res.status !== exp_res.status || act_res.value !== exp_res.value ||
            act_res.prio !== exp_res.prio) begin
          $display({"%0t: mismatch expected status %0d value %h priority %h, ",
                    "actual status %0d value %h priority %h"},
                   $time, exp_res.status, exp_res.value, exp_res.prio,
                   act_res.status, act_res.value, act_res.prio);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_dequeue();
    send_item(CMD_DEQ, 32'h8000_0000, 16'h7fff);
    send_item(CMD_DEQ, 32'h7fff_ffff, 16'h8000);
  endtask

  // extremes of priority, ties at max, min and zero, then two rejected items
  task automatic test_fill_and_reject();
    send_item(CMD_ENQ, 32'h0000_0001, 16'h8000);
    send_item(CMD_ENQ, 32'h0000_0002, 16'h7fff);
    send_item(CMD_ENQ, 32'h0000_0003, 16'h0000);
    send_item(CMD_ENQ, 32'h0000_0004, 16'h0000);
    send_item(CMD_ENQ, 32'hffff_ffff, 16'hffff);
    send_item(CMD_ENQ, 32'h8000_0000, 16'h0001);
    send_item(CMD_ENQ, 32'h7fff_ffff, 16'h7fff);
    send_item(CMD_ENQ, 32'h0000_0000, 16'h8000);
    send_item(CMD_ENQ, 32'hdead_beef, 16'h7fff);
    send_item(CMD_ENQ, 32'h5555_aaaa, 16'h8000);
  endtask

  task automatic test_drain_in_order();
    for (int i = 0; i < DEPTH + 1; i++) send_item(CMD_DEQ, $urandom, PRI_W'($urandom));
    // slot freed by a dequeue is reused right away
    send_item(CMD_ENQ, 32'h1234_5678, 16'h0042);
    send_item(CMD_DEQ, 32'h0, 16'h0);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int enq_bias;
    cmd_t cmd;
    logic [PRI_W-1:0] pri;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    enq_bias = 50;
    for (int n = 0; n < n_items; n++) begin
      // shifting bias lets the queue both fill up and run dry
      if (n % 24 == 0) enq_bias = $urandom_range(15, 85);
      cmd = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
      case ($urandom_range(3))
        0:       pri = PRI_W'(int'($urandom_range(0, 6)) - 3);
        1:       pri = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: pri = PRI_W'($urandom);
      endcase
      send_item(cmd, $urandom, pri);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_dequeue();
    test_fill_and_reject();
    test_drain_in_order();
    wait_drained();

    test_random_traffic(0, 0, 500);
    test_random_traffic(65, 0, 500);
    test_random_traffic(0, 65, 500);
    test_random_traffic(33, 33, 500);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
